// ===== hw/rtl/bapd_pkg.sv =====
// shared types and constants for the advertising data parser
package bapd_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [7:0] AD_FLAGS       = 8'h01;
	localparam logic [7:0] AD_UUID16_INC  = 8'h02;
	localparam logic [7:0] AD_UUID16_CMP  = 8'h03;
	localparam logic [7:0] AD_UUID32_INC  = 8'h04;
	localparam logic [7:0] AD_UUID32_CMP  = 8'h05;
	localparam logic [7:0] AD_UUID128_INC = 8'h06;
	localparam logic [7:0] AD_UUID128_CMP = 8'h07;
	localparam logic [7:0] AD_NAME_SHORT  = 8'h08;
	localparam logic [7:0] AD_NAME_FULL   = 8'h09;
	localparam logic [7:0] AD_TX_POWER    = 8'h0A;
	localparam logic [7:0] AD_SVC_DATA16  = 8'h16;
	localparam logic [7:0] AD_APPEARANCE  = 8'h19;
	localparam logic [7:0] AD_SVC_DATA32  = 8'h20;
	localparam logic [7:0] AD_SVC_DATA128 = 8'h21;
	localparam logic [7:0] AD_MFG_DATA    = 8'hFF;

	typedef enum logic [3:0] {
		KIND_FLAGS       = 4'd0,
		KIND_NAME_BYTE   = 4'd1,
		KIND_TX_POWER    = 4'd2,
		KIND_APPEARANCE  = 4'd3,
		KIND_UUID16      = 4'd4,
		KIND_UUID32      = 4'd5,
		KIND_UUID128_LO  = 4'd6,
		KIND_UUID128_HI  = 4'd7,
		KIND_MFG_ID      = 4'd8,
		KIND_MFG_BYTE    = 4'd9,
		KIND_SVC_UUID16  = 4'd10,
		KIND_SVC_UUID32  = 4'd11,
		KIND_SVC_UUID128_LO = 4'd12,
		KIND_SVC_UUID128_HI = 4'd13,
		KIND_SVC_BYTE    = 4'd14,
		KIND_END         = 4'd15
	} bapd_kind_t;

	typedef enum logic [1:0] {
		PH_LEN   = 2'd0,
		PH_TYPE  = 2'd1,
		PH_VALUE = 2'd2
	} bapd_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] frame_length;
	} bapd_in_t;

	typedef struct packed {
		logic [3:0]  record_kind;
		logic [63:0] record_value;
		logic [7:0]  byte_index;
		logic        last_of_run;
	} bapd_out_t;

	// all records caused by one input byte
	typedef struct packed {
		logic        has_main;
		bapd_kind_t  main_kind;
		logic [63:0] main_value;
		logic [7:0]  main_index;
		logic        has_hi;
		bapd_kind_t  hi_kind;
		logic [63:0] hi_value;
		logic        has_end;
		logic        end_flag;
	} bapd_bundle_t;

endpackage

// ===== hw/rtl/bapd_parse.sv =====
// input register and structure walker, one byte per cycle while the queue is not full
module bapd_parse #(
	parameter int FRAME_MAX = 255,
	parameter int NAME_MAX = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  bapd_pkg::bapd_in_t    byte_item,
	input  logic                  q_full,
	output logic                  push,
	output bapd_pkg::bapd_bundle_t bundle
);
	import bapd_pkg::*;

	localparam logic [7:0] FrameMaxB = 8'(FRAME_MAX);
	localparam logic [7:0] NameMaxB = 8'(NAME_MAX);

	logic        valid_s1;
	bapd_in_t    item_s1;
	logic        advance;

	logic [7:0]  pos_q, pos_d;
	bapd_phase_t phase_q, phase_d;
	logic [7:0]  rem_q, rem_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  off_q, off_d;
	logic [1:0][63:0] acc_q, acc_d, acc_new;
	logic        name_acc_q, name_acc_d;
	logic        skip_q, skip_d;
	logic [7:0]  kept_q, kept_d;

	logic [7:0]  b;
	logic [7:0]  len_clip;
	logic [7:0]  len_eff;
	logic        frame_end;
	logic        overrun;
	logic        in_value;
	logic        put_en;
	logic [3:0]  slot;
	logic [7:0]  dlen;
	logic [7:0]  rem_dec;
	logic        group_done;

	assign advance = valid_s1 && !q_full;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	assign b = item_s1.data_byte;
	assign len_clip = (item_s1.frame_length > FrameMaxB) ? FrameMaxB : item_s1.frame_length;
	assign len_eff = (len_clip == 8'd0) ? 8'd1 : len_clip;
	assign frame_end = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_eff};
	assign overrun = !skip_q && (phase_q == PH_LEN) && (b != 8'd0)
		&& (({2'b0, pos_q} + 10'd1 + {2'b0, b}) > {2'b0, len_eff});
	assign in_value = !skip_q && (phase_q == PH_VALUE);
	assign dlen = rem_q - 8'd1;
	assign rem_dec = rem_q - 8'd1;

	// accumulator byte placement
	always_comb begin
		put_en = 1'b0;
		slot = off_q[3:0];
		group_done = 1'b0;
		unique case (type_q)
			AD_APPEARANCE: put_en = off_q < 8'd2;
			AD_UUID16_INC, AD_UUID16_CMP: begin
				put_en = 1'b1;
				slot = {3'b0, off_q[0]};
				group_done = off_q[0];
			end
			AD_UUID32_INC, AD_UUID32_CMP: begin
				put_en = 1'b1;
				slot = {2'b0, off_q[1:0]};
				group_done = off_q[1:0] == 2'd3;
			end
			AD_UUID128_INC, AD_UUID128_CMP: begin
				put_en = 1'b1;
				group_done = off_q[3:0] == 4'd15;
			end
			AD_MFG_DATA, AD_SVC_DATA16: put_en = off_q < 8'd2;
			AD_SVC_DATA32: put_en = off_q < 8'd4;
			AD_SVC_DATA128: put_en = off_q < 8'd16;
			default: put_en = 1'b0;
		endcase
		acc_new = acc_q;
		if (in_value && put_en) begin
			acc_new[slot[3]] = acc_q[slot[3]] | ({56'b0, b} << {slot[2:0], 3'b000});
		end
	end

	// next state
	always_comb begin
		pos_d = pos_q + 8'd1;
		phase_d = phase_q;
		rem_d = rem_q;
		type_d = type_q;
		off_d = off_q;
		acc_d = acc_q;
		name_acc_d = name_acc_q;
		skip_d = skip_q | overrun;
		kept_d = kept_q;
		if (!skip_q) begin
			unique case (phase_q)
				PH_LEN: begin
					if (b != 8'd0 && !overrun) begin
						rem_d = b;
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_d = b;
					rem_d = dlen;
					off_d = 8'd0;
					acc_d = '0;
					name_acc_d = 1'b0;
					if ((b == AD_NAME_SHORT || b == AD_NAME_FULL) && dlen > kept_q) begin
						name_acc_d = 1'b1;
						kept_d = (dlen > NameMaxB) ? NameMaxB : dlen;
					end
					phase_d = (dlen == 8'd0) ? PH_LEN : PH_VALUE;
				end
				PH_VALUE: begin
					acc_d = group_done ? '0 : acc_new;
					off_d = off_q + 8'd1;
					rem_d = rem_dec;
					if (rem_dec == 8'd0) begin
						phase_d = PH_LEN;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
		if (frame_end) begin
			pos_d = 8'd0;
			phase_d = PH_LEN;
			rem_d = 8'd0;
			type_d = 8'd0;
			off_d = 8'd0;
			acc_d = '0;
			name_acc_d = 1'b0;
			skip_d = 1'b0;
			kept_d = 8'd0;
		end
	end

	// records for this byte
	always_comb begin
		bundle = '0;
		bundle.main_kind = KIND_FLAGS;
		bundle.hi_kind = KIND_UUID128_HI;
		if (in_value) begin
			unique case (type_q)
				AD_FLAGS: begin
					bundle.has_main = off_q == 8'd0;
					bundle.main_kind = KIND_FLAGS;
					bundle.main_value = {56'b0, b};
				end
				AD_TX_POWER: begin
					bundle.has_main = off_q == 8'd0;
					bundle.main_kind = KIND_TX_POWER;
					bundle.main_value = {56'b0, b};
				end
				AD_APPEARANCE: begin
					bundle.has_main = off_q == 8'd1;
					bundle.main_kind = KIND_APPEARANCE;
					bundle.main_value = acc_new[0];
				end
				AD_NAME_SHORT, AD_NAME_FULL: begin
					bundle.has_main = name_acc_q && (off_q < NameMaxB);
					bundle.main_kind = KIND_NAME_BYTE;
					bundle.main_value = {56'b0, b};
					bundle.main_index = off_q;
				end
				AD_UUID16_INC, AD_UUID16_CMP: begin
					bundle.has_main = group_done;
					bundle.main_kind = KIND_UUID16;
					bundle.main_value = acc_new[0];
				end
				AD_UUID32_INC, AD_UUID32_CMP: begin
					bundle.has_main = group_done;
					bundle.main_kind = KIND_UUID32;
					bundle.main_value = acc_new[0];
				end
				AD_UUID128_INC, AD_UUID128_CMP: begin
					bundle.has_main = group_done;
					bundle.main_kind = KIND_UUID128_LO;
					bundle.main_value = acc_new[0];
					bundle.has_hi = group_done;
					bundle.hi_kind = KIND_UUID128_HI;
					bundle.hi_value = acc_new[1];
				end
				AD_MFG_DATA: begin
					if (off_q < 8'd2) begin
						bundle.has_main = off_q == 8'd1;
						bundle.main_kind = KIND_MFG_ID;
						bundle.main_value = acc_new[0];
					end else begin
						bundle.has_main = 1'b1;
						bundle.main_kind = KIND_MFG_BYTE;
						bundle.main_value = {56'b0, b};
						bundle.main_index = off_q;
					end
				end
				AD_SVC_DATA16: begin
					if (off_q < 8'd2) begin
						bundle.has_main = off_q == 8'd1;
						bundle.main_kind = KIND_SVC_UUID16;
						bundle.main_value = acc_new[0];
					end else begin
						bundle.has_main = 1'b1;
						bundle.main_kind = KIND_SVC_BYTE;
						bundle.main_value = {56'b0, b};
						bundle.main_index = off_q;
					end
				end
				AD_SVC_DATA32: begin
					if (off_q < 8'd4) begin
						bundle.has_main = off_q == 8'd3;
						bundle.main_kind = KIND_SVC_UUID32;
						bundle.main_value = acc_new[0];
					end else begin
						bundle.has_main = 1'b1;
						bundle.main_kind = KIND_SVC_BYTE;
						bundle.main_value = {56'b0, b};
						bundle.main_index = off_q;
					end
				end
				AD_SVC_DATA128: begin
					if (off_q < 8'd16) begin
						bundle.has_main = off_q == 8'd15;
						bundle.main_kind = KIND_SVC_UUID128_LO;
						bundle.main_value = acc_new[0];
						bundle.has_hi = off_q == 8'd15;
						bundle.hi_kind = KIND_SVC_UUID128_HI;
						bundle.hi_value = acc_new[1];
					end else begin
						bundle.has_main = 1'b1;
						bundle.main_kind = KIND_SVC_BYTE;
						bundle.main_value = {56'b0, b};
						bundle.main_index = off_q;
					end
				end
				default: bundle.has_main = 1'b0;
			endcase
		end
		bundle.has_end = frame_end;
		bundle.end_flag = skip_q | overrun;
	end

	assign push = advance && (bundle.has_main || bundle.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
			phase_q <= PH_LEN;
			rem_q <= 8'd0;
			type_q <= 8'd0;
			off_q <= 8'd0;
			acc_q <= '0;
			name_acc_q <= 1'b0;
			skip_q <= 1'b0;
			kept_q <= 8'd0;
		end else if (advance) begin
			pos_q <= pos_d;
			phase_q <= phase_d;
			rem_q <= rem_d;
			type_q <= type_d;
			off_q <= off_d;
			acc_q <= acc_d;
			name_acc_q <= name_acc_d;
			skip_q <= skip_d;
			kept_q <= kept_d;
		end
	end

`ifndef ASSERT_OFF
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= NameMaxB)
		else $error("kept name length above limit");
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_LEN) |-> (rem_q != 8'd0))
		else $error("structure active with nothing remaining");
	a_skip_phase: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (phase_q == PH_LEN))
		else $error("skipping while inside a structure");
`endif

endmodule

// ===== hw/rtl/bapd_queue.sv =====
// small queue of per-byte record bundles
module bapd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bapd_pkg::bapd_bundle_t push_data,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output bapd_pkg::bapd_bundle_t head
);
	import bapd_pkg::*;

	bapd_bundle_t           mem_q [QDepth];
	logic [QPtrW-1:0]       wr_ptr_q;
	logic [QPtrW-1:0]       rd_ptr_q;
	logic [QCntW-1:0]       count_q;

	assign full = count_q == QCntW'(QDepth);
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop && head_valid) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			unique case ({push && !full, pop && head_valid})
				2'b10: count_q <= count_q + QCntW'(1);
				2'b01: count_q <= count_q - QCntW'(1);
				2'b00, 2'b11: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("queue count past depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/bapd_unroll.sv =====
// splits record bundles into single records behind an output register
module bapd_unroll (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  bapd_pkg::bapd_bundle_t head,
	output logic                   pop,
	output logic                   record_valid,
	input  logic                   record_ready,
	output bapd_pkg::bapd_out_t    record
);
	import bapd_pkg::*;

	bapd_bundle_t cur_q;
	logic [2:0]   mask_q;
	logic         rec_valid_q;
	bapd_out_t    rec_q;

	bapd_bundle_t src;
	logic [2:0]   src_mask;
	logic [2:0]   rem_mask;
	logic         load;
	bapd_out_t    rec_d;

	assign load = !rec_valid_q || record_ready;

	always_comb begin
		if (mask_q != 3'b000) begin
			src = cur_q;
			src_mask = mask_q;
		end else begin
			src = head;
			src_mask = head_valid ? {head.has_end, head.has_hi, head.has_main} : 3'b000;
		end
		rec_d = '0;
		priority if (src_mask[0]) begin
			rec_d.record_kind = src.main_kind;
			rec_d.record_value = src.main_value;
			rec_d.byte_index = src.main_index;
			rem_mask = src_mask & 3'b110;
		end else if (src_mask[1]) begin
			rec_d.record_kind = src.hi_kind;
			rec_d.record_value = src.hi_value;
			rem_mask = src_mask & 3'b100;
		end else begin
			rec_d.record_kind = KIND_END;
			rec_d.record_value = {63'b0, src.end_flag};
			rem_mask = 3'b000;
		end
		rec_d.last_of_run = rem_mask == 3'b000;
	end

	assign pop = load && (mask_q == 3'b000) && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'b000;
			rec_valid_q <= 1'b0;
		end else if (load) begin
			rec_valid_q <= src_mask != 3'b000;
			if (src_mask != 3'b000) begin
				mask_q <= rem_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load && src_mask != 3'b000) begin
			rec_q <= rec_d;
		end
	end

	assign record_valid = rec_valid_q;
	assign record = rec_q;

endmodule

// ===== hw/rtl/ble_advertising_data_parser.sv =====
// top level of the advertising data parser
// Takes one frame byte per transfer on the byte channel, together with the
// frame length, and gives one typed record per transfer on the record
// channel. A byte is accepted every cycle while the record queue has room;
// an accepted byte goes through the input register and the bundle queue to
// the output register. The record side drains one record per cycle while
// record_ready is high, so the two or three records of one byte (a 128-bit
// UUID, possibly with the frame end) leave in turn, and a four-entry queue
// of per-byte record bundles lets the byte side keep running meanwhile. Each
// byte's last record has last_of_run; every frame closes with an end record.
module ble_advertising_data_parser #(
	parameter int FRAME_MAX = 255,
	parameter int NAME_MAX = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  bapd_pkg::bapd_in_t  byte_item,
	output logic                record_valid,
	input  logic                record_ready,
	output bapd_pkg::bapd_out_t record
);
	import bapd_pkg::*;

	logic         push;
	bapd_bundle_t bundle;
	logic         q_full;
	logic         pop;
	logic         head_valid;
	bapd_bundle_t head;

	bapd_parse #(
		.FRAME_MAX(FRAME_MAX),
		.NAME_MAX(NAME_MAX)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.q_full(q_full),
		.push(push),
		.bundle(bundle)
	);

	bapd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(bundle),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	bapd_unroll u_unroll (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.record_valid(record_valid),
		.record_ready(record_ready),
		.record(record)
	);

endmodule
